[rtl/wwlm_pkg.sv]
// shared types, character codes and helpers for the whole-word line matcher
package wwlm_pkg;

  // character codes
  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // keyword storage and line counter
  localparam int KEY_BYTES = 16;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int LINE_W    = 16;
  localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;
  localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;

  // configuration register indexes
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYWORD_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYWORD_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYWORD_LENGTH = 2'd2;
  localparam int KLEN_W = 5;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [7:0] byte_t;

  // one classified text byte
  typedef struct packed {
    byte_t folded;
    logic  newline;
    logic  delim;
    logic  last;
  } text_entry_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic        valid;
    text_entry_t entry;
  } queue_head_t;

  // fold A-Z to lower case
  function automatic byte_t fold(input byte_t b);
    byte_t r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  // space, zero byte or ascii punctuation
  function automatic logic is_delim(input byte_t c);
    logic r;
    r = (c == CHAR_NUL) || (c == CHAR_SPACE) ||
        (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
        (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    return r;
  endfunction

endpackage

[rtl/wwlm_if.sv]
// stream interfaces for text bytes in and matching line numbers out

// text byte requests
interface wwlm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// line number requests
interface wwlm_line_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_number;

  modport source (output valid, output line_number, input ready);
  modport sink (input valid, input line_number, output ready);
endinterface

[rtl/whole_word_line_matcher.sv]
// top level: configuration registers, front end, queue and back end
//
// Whole-word line matcher. Text bytes arrive on the text stream, one per cycle
// while text.ready is high; A-Z fold to lower case. Each line (closed by a
// newline byte or by end_of_text) that holds the configured keyword as a whole
// word gives one request on the lines stream carrying its one-based line number,
// saturating at 65535. The front end takes one byte every cycle into a two-entry
// queue while it has room, and the back end retires one queued byte every cycle,
// so the sustained rate is one byte per cycle whenever the lines stream is not
// stalled; the result register loads when the back end pops the closing byte from
// the queue. The user must write the keyword through cfg_write, cfg_index and
// cfg_data (low bytes, high bytes, length) only while the block is idle; the block
// itself does not enforce this. end_of_text restarts line counting at one.
module whole_word_line_matcher #(
  parameter int KEY_LEN = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  wwlm_text_if.sink                          text,
  wwlm_line_if.source                        lines,
  input  logic                               cfg_write,
  input  logic [wwlm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wwlm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [wwlm_pkg::CFG_DATA_W-1:0] keyword_low;
  logic [wwlm_pkg::CFG_DATA_W-1:0] keyword_high;
  logic [wwlm_pkg::KLEN_W-1:0]     keyword_length;
  wwlm_pkg::queue_head_t           head;
  logic                            pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_low    <= '0;
      keyword_high   <= '0;
      keyword_length <= wwlm_pkg::KLEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wwlm_pkg::CFG_KEYWORD_LOW:    keyword_low    <= cfg_data;
        wwlm_pkg::CFG_KEYWORD_HIGH:   keyword_high   <= cfg_data;
        wwlm_pkg::CFG_KEYWORD_LENGTH: keyword_length <= cfg_data[wwlm_pkg::KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // byte classification and queue
  wwlm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .head (head),
    .pop  (pop)
  );

  // window compare and line results
  wwlm_back #(
    .KEY_LEN (KEY_LEN)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .keyword        ({keyword_high, keyword_low}),
    .keyword_length (keyword_length),
    .lines          (lines)
  );

endmodule

[rtl/wwlm_front.sv]
// front end: folds and classifies text bytes and queues them for the back end
module wwlm_front (
  input  logic                 clk,
  input  logic                 rst,
  wwlm_text_if.sink            text,
  output wwlm_pkg::queue_head_t head,
  input  logic                 pop
);

  localparam int PTR_W = $clog2(wwlm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(wwlm_pkg::QUEUE_DEPTH + 1);

  wwlm_pkg::text_entry_t entries [wwlm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  wwlm_pkg::text_entry_t incoming;

  // classify the incoming byte
  always_comb begin
    incoming.folded  = wwlm_pkg::fold(text.text_byte);
    incoming.newline = (text.text_byte == wwlm_pkg::CHAR_NEWLINE);
    incoming.delim   = wwlm_pkg::is_delim(incoming.folded);
    incoming.last    = text.end_of_text;
  end

  assign text.ready = (count != CNT_W'(wwlm_pkg::QUEUE_DEPTH));
  assign push       = text.valid && text.ready;

  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(wwlm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(wwlm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue never overfills and never pops empty
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(wwlm_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

[rtl/wwlm_back.sv]
// back end: byte window, whole-word compare, line counting and result register
module wwlm_back #(
  parameter int KEY_LEN = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  wwlm_pkg::queue_head_t                   head,
  output logic                                    pop,
  input  logic [wwlm_pkg::KEY_W-1:0]              keyword,
  input  logic [wwlm_pkg::KLEN_W-1:0]             keyword_length,
  wwlm_line_if.source                             lines
);

  localparam int WIN  = KEY_LEN + 1;
  localparam int BW   = $clog2(WIN + 1);
  localparam int LMAX = (KEY_LEN < wwlm_pkg::KEY_BYTES) ? KEY_LEN : wwlm_pkg::KEY_BYTES;

  logic [WIN-1:0][7:0] win;
  logic [WIN-1:0][7:0] win_shift;
  logic [WIN-1:0][7:0] eval_win;
  logic [BW-1:0]       bil;
  logic [BW-1:0]       bil_shift;
  logic [BW-1:0]       eval_bil;
  logic                has_match;
  logic [wwlm_pkg::LINE_W-1:0] current_line;
  logic                out_valid;
  logic [wwlm_pkg::LINE_W-1:0] line_number;
  logic [wwlm_pkg::KLEN_W-1:0] len;
  logic                match_before;
  logic                end_hit;
  logic                line_end;
  logic                hit_line;
  logic                out_load;

  // whole-word keyword ending at the newest window byte
  function automatic logic word_end(input logic [WIN-1:0][7:0] w,
                                    input logic [BW-1:0] n,
                                    input logic [wwlm_pkg::KLEN_W-1:0] klen,
                                    input logic [wwlm_pkg::KEY_W-1:0] key);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int l = 1; l <= LMAX; l++) begin
      if (klen == wwlm_pkg::KLEN_W'(l)) begin
        eq = 1'b1;
        for (int i = 0; i < l; i++) begin
          if (w[l-1-i] != key[8*i +: 8]) begin
            eq = 1'b0;
          end
        end
        if (n < BW'(l)) begin
          eq = 1'b0;
        end else if (n != BW'(l) && !wwlm_pkg::is_delim(w[l])) begin
          eq = 1'b0;
        end
        hit = eq;
      end
    end
    return hit;
  endfunction

  // keyword length clamped to the usable range
  always_comb begin
    if (keyword_length == '0) begin
      len = wwlm_pkg::KLEN_W'(1);
    end else if (keyword_length > wwlm_pkg::KLEN_W'(LMAX)) begin
      len = wwlm_pkg::KLEN_W'(LMAX);
    end else begin
      len = keyword_length;
    end
  end

  // window after taking the head byte
  assign win_shift = {win[WIN-2:0], head.entry.folded};
  assign bil_shift = (bil < BW'(WIN)) ? bil + 1'b1 : bil;

  // compare before the shift (delimiter closes a word) and at the line end
  assign match_before = head.entry.delim && word_end(win, bil, len, keyword);
  assign eval_win     = head.entry.newline ? win : win_shift;
  assign eval_bil     = head.entry.newline ? bil : bil_shift;
  assign end_hit      = word_end(eval_win, eval_bil, len, keyword);
  assign line_end     = head.entry.newline || head.entry.last;
  assign hit_line     = has_match || (!head.entry.newline && match_before) || end_hit;

  assign pop      = head.valid && (!out_valid || lines.ready);
  assign out_load = pop && line_end && hit_line;

  // window bytes
  always_ff @(posedge clk) begin
    if (pop && !head.entry.newline) begin
      win <= win_shift;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      bil          <= '0;
      has_match    <= 1'b0;
      current_line <= wwlm_pkg::LINE_FIRST;
    end else if (pop) begin
      if (line_end) begin
        bil       <= '0;
        has_match <= 1'b0;
        if (head.entry.last) begin
          current_line <= wwlm_pkg::LINE_FIRST;
        end else if (current_line != wwlm_pkg::LINE_MAX) begin
          current_line <= current_line + 1'b1;
        end
      end else begin
        bil       <= bil_shift;
        has_match <= has_match || match_before;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (lines.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line_number <= current_line;
    end
  end

  assign lines.valid       = out_valid;
  assign lines.line_number = line_number;

  // results come only from line ends, lines restart empty, numbers are one-based
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (head.entry.newline || head.entry.last))
    else $error("result loaded without a line end");
  assert property (@(posedge clk) disable iff (rst)
    (pop && line_end) |=> (bil == '0 && !has_match))
    else $error("line state not cleared at line end");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_number != '0))
    else $error("zero line number presented");

endmodule
